// File: rtl/xml_filtered_crc32_summer_core_macros.svh
// assertion macros for the filtered crc-32 summer
// used by the top level; relies on clk_i and rst_ni in the including scope
`ifndef XML_FILTERED_CRC32_SUMMER_CORE_MACROS_SVH
`define XML_FILTERED_CRC32_SUMMER_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define XFCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define XFCS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/xfcs_pkg.sv
// shared types and constants of the filtered crc-32 summer
// no dependencies
package xfcs_pkg;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned WIN_IDX_W = 2;
  localparam int unsigned WIN_CNT_W = 3;

  localparam logic [7:0] CHAR_LT   = 8'h3c;
  localparam logic [7:0] CHAR_GT   = 8'h3e;
  localparam logic [7:0] CHAR_BANG = 8'h21;
  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_CR   = 8'h0d;

  // one lookahead window slot
  typedef struct packed {
    logic [7:0] data;
    logic       filt;
  } win_entry_t;

  // sequencer to crc unit
  typedef struct packed {
    logic       init;
    logic       load;
    logic [7:0] data;
  } crc_ctrl_t;

  // verdict of the filter for one byte
  typedef struct packed {
    logic keep;
    logic in_comment;
  } decide_t;

endpackage

// File: rtl/xfcs_filter.sv
// keep/drop decision for one byte leaving the lookahead window
// depends on xfcs_pkg
module xfcs_filter import xfcs_pkg::*; (
  input  win_entry_t head_i,
  input  logic       can_open_i,
  input  logic [7:0] next1_i,
  input  logic [7:0] next2_i,
  input  logic [7:0] next3_i,
  input  logic       in_comment_i,
  input  logic [7:0] raw0_i,
  input  logic [7:0] raw1_i,
  output decide_t    verdict_o
);

  logic opens;
  logic closes;

  always_comb begin
    opens  = (head_i.data == CHAR_LT) && can_open_i && (next1_i == CHAR_BANG)
             && (next2_i == CHAR_DASH) && (next3_i == CHAR_DASH);
    closes = (head_i.data == CHAR_GT) && (raw0_i == CHAR_DASH) && (raw1_i == CHAR_DASH);
    verdict_o.keep       = 1'b1;
    verdict_o.in_comment = in_comment_i;
    if (head_i.filt) begin
      if (in_comment_i) begin
        verdict_o.in_comment = !closes;
        verdict_o.keep       = 1'b0;
      end else if (opens) begin
        verdict_o.in_comment = 1'b1;
        verdict_o.keep       = 1'b0;
      end else if (head_i.data inside {CHAR_SP, CHAR_TAB, CHAR_LF, CHAR_CR}) begin
        verdict_o.keep = 1'b0;
      end
    end
  end

endmodule

// File: rtl/xfcs_crc_unit.sv
// bit-serial reflected crc-32 register, one polynomial step per cycle
// depends on xfcs_pkg
module xfcs_crc_unit import xfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctrl_t   ctrl_i,
  output logic        busy_o,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
      cnt_d = 4'd0;
    end else if (ctrl_i.load) begin
      crc_d = crc_q ^ {24'd0, ctrl_i.data};
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      crc_d = (crc_q >> 1) ^ (crc_q[0] ? CRC_POLY : 32'd0);
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      cnt_q <= 4'd0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign crc_o  = crc_q;

endmodule

// File: rtl/xml_filtered_crc32_summer_core.sv
// top level of the filtered crc-32 summer: stream ports, sequencer, lookahead window
// depends on xfcs_pkg, xfcs_filter, xfcs_crc_unit and the macros header

// Takes one byte per input transaction and builds the reflected CRC-32 (start all
// ones, final inversion) of each file. A transaction with first_byte starts a file;
// one with last_byte flushes the four-byte lookahead window and produces one output
// transaction with the file CRC and the wrapping sum of all file CRCs since reset
// or the last clear_total. Filtered content bytes that are whitespace or lie
// inside an XML comment are skipped. A byte that goes into a window that is not
// yet full is written straight into it. Once the window is full each byte first
// retires the oldest window entry: a dropped entry only passes the decide step, a
// kept one also goes through the bit-serial CRC unit (one polynomial step per
// cycle), and the byte is then written into the freed slot. The last byte of a
// file then flushes up to four entries the same way, and a finish step posts the
// result. The input is not ready while a byte is being worked on; a finished
// result waits in an output register and only blocks the sequencer when the next
// file ends before it was taken.
`include "xml_filtered_crc32_summer_core_macros.svh"

module xml_filtered_crc32_summer_core import xfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser_i,   // [0] xml_filter, [1] first_byte, [2] clear_total
  input  logic        s_axis_tlast_i,   // last_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [31:0] file_crc, [63:32] total_sum
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CRC,
    ST_PUSH,
    ST_FLUSH,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [WIN_CNT_W-1:0]    win_cnt_q;     // occupied window slots, 0..4
  logic                    flushing_q;    // draining the window at end of file
  logic                    in_comment_q;
  logic [7:0]              raw0_q, raw1_q; // last two decided bytes, newest first
  logic [31:0]             total_q;
  win_entry_t              pend_q;        // byte waiting for a free window slot
  logic                    pend_last_q;
  logic                    m_valid_q;
  logic [63:0]             m_data_q;

  win_entry_t              win_q [WIN_DEPTH];

  // input transaction and its fields
  logic                    s_fire;
  win_entry_t              s_entry;
  logic                    s_first;
  logic                    s_clear;
  logic [WIN_CNT_W-1:0]    eff_cnt;      // occupancy after an optional file restart

  // window write and shift controls
  logic                    win_we;
  logic [WIN_IDX_W-1:0]    win_widx;
  win_entry_t              win_wdata;
  logic                    win_shift;

  crc_ctrl_t               crc_ctrl;
  logic                    crc_busy;
  logic [31:0]             crc_val;
  decide_t                 verdict;
  logic [31:0]             file_crc;
  logic [31:0]             new_total;
  logic                    out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_entry.data    = s_axis_tdata_i;
  assign s_entry.filt    = s_axis_tuser_i[0];
  assign s_first         = s_axis_tuser_i[1];
  assign s_clear         = s_axis_tuser_i[2];
  assign eff_cnt         = s_first ? '0 : win_cnt_q;

  assign file_crc  = ~crc_val;
  assign new_total = total_q + file_crc;
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // oldest window entry is decided; the "!--" test looks at the three after it
  xfcs_filter u_filter (
    .head_i       (win_q[0]),
    .can_open_i   (!flushing_q),
    .next1_i      (win_q[1].data),
    .next2_i      (win_q[2].data),
    .next3_i      (win_q[3].data),
    .in_comment_i (in_comment_q),
    .raw0_i       (raw0_q),
    .raw1_i       (raw1_q),
    .verdict_o    (verdict)
  );

  xfcs_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  // crc unit commands and window writes
  always_comb begin
    crc_ctrl.init = 1'b0;
    crc_ctrl.load = 1'b0;
    crc_ctrl.data = win_q[0].data;
    win_we        = 1'b0;
    win_widx      = eff_cnt[WIN_IDX_W-1:0];
    win_wdata     = s_entry;
    win_shift     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          crc_ctrl.init = s_first;
          win_we        = (eff_cnt != WIN_CNT_W'(WIN_DEPTH));
        end
      end
      ST_DECIDE: begin
        crc_ctrl.load = verdict.keep;
        win_shift     = 1'b1;
      end
      ST_PUSH: begin
        win_we    = 1'b1;
        win_widx  = win_cnt_q[WIN_IDX_W-1:0];
        win_wdata = pend_q;
      end
      default: begin
      end
    endcase
  end

  // lookahead window: contents are only read below the fill count
  always_ff @(posedge clk_i) begin
    if (win_shift) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
    end else if (win_we) begin
      win_q[win_widx] <= win_wdata;
    end
  end

  // sequencer, filter state, running total and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_cnt_q    <= '0;
      flushing_q   <= 1'b0;
      in_comment_q <= 1'b0;
      raw0_q       <= 8'd0;
      raw1_q       <= 8'd0;
      total_q      <= 32'd0;
      pend_q       <= '0;
      pend_last_q  <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= 64'd0;
    end else begin
      // result register: loaded out of the finish step, cleared when taken
      if ((state_q == ST_FINISH) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_first) begin
              in_comment_q <= 1'b0;
              raw0_q       <= 8'd0;
              raw1_q       <= 8'd0;
              if (s_clear) begin
                total_q <= 32'd0;
              end
            end
            if (eff_cnt == WIN_CNT_W'(WIN_DEPTH)) begin
              // window full: retire the oldest entry first
              pend_q      <= s_entry;
              pend_last_q <= s_axis_tlast_i;
              win_cnt_q   <= eff_cnt;
              state_q     <= ST_DECIDE;
            end else begin
              win_cnt_q <= eff_cnt + 1'b1;
              if (s_axis_tlast_i) begin
                flushing_q <= 1'b1;
                state_q    <= ST_FLUSH;
              end
            end
          end
        end
        ST_DECIDE: begin
          in_comment_q <= verdict.in_comment;
          raw1_q       <= raw0_q;
          raw0_q       <= win_q[0].data;
          win_cnt_q    <= win_cnt_q - 1'b1;
          if (verdict.keep) begin
            state_q <= ST_CRC;
          end else begin
            state_q <= flushing_q ? ST_FLUSH : ST_PUSH;
          end
        end
        ST_CRC: begin
          if (!crc_busy) begin
            state_q <= flushing_q ? ST_FLUSH : ST_PUSH;
          end
        end
        ST_PUSH: begin
          win_cnt_q <= win_cnt_q + 1'b1;
          if (pend_last_q) begin
            flushing_q <= 1'b1;
            state_q    <= ST_FLUSH;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          state_q <= (win_cnt_q == '0) ? ST_FINISH : ST_DECIDE;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_data_q   <= {new_total, file_crc};
            total_q    <= new_total;
            flushing_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // window never holds more than its depth
  `XFCS_ASSERT_ALWAYS(a_win_cnt_bound, win_cnt_q <= WIN_CNT_W'(WIN_DEPTH), "window overfilled")
  // no new byte is taken while the crc unit is still shifting
  `XFCS_ASSERT_IMPLIES(a_ready_crc_idle, s_axis_tready_o, !crc_busy, "ready while crc busy")
  // a result only appears out of the finish step
  `XFCS_ASSERT_IMPLIES(a_result_source, $rose(m_valid_q), $past(state_q) == ST_FINISH, "stray result")

endmodule
